// ----- rtl/cdl_pkg.sv -----
// Shared types and constants of the dilated convolution layer.
// Holds the sequencer states, mode codes and the sigmoid breakpoint table.
// No dependencies.
`default_nettype none
package cdl_pkg;

    localparam int ACC_W = 48;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_RND,
        ST_ACT,
        ST_FIN,
        ST_OUT
    } cdl_state_t;

    localparam logic [1:0] MODE_WEIGHT  = 2'd0;
    localparam logic [1:0] MODE_BIAS    = 2'd1;
    localparam logic [1:0] MODE_SAMPLE  = 2'd2;
    localparam logic [1:0] MODE_COMPUTE = 2'd3;

    localparam logic [1:0] PAD_VALID = 2'd0;
    localparam logic [1:0] PAD_CLAMP = 2'd2;

    localparam logic [2:0] ACT_RELU    = 3'd1;
    localparam logic [2:0] ACT_TANH    = 3'd2;
    localparam logic [2:0] ACT_SIGMOID = 3'd3;
    localparam logic [2:0] ACT_LEAKY   = 3'd4;

    localparam logic [2:0] REG_KERNEL   = 3'd0;
    localparam logic [2:0] REG_DILATION = 3'd1;
    localparam logic [2:0] REG_PADDING  = 3'd2;
    localparam logic [2:0] REG_ACT      = 3'd3;
    localparam logic [2:0] REG_IN_CH    = 3'd4;
    localparam logic [2:0] REG_OUT_CH   = 3'd5;
    localparam logic [2:0] REG_WIDTH    = 3'd6;
    localparam logic [2:0] REG_HEIGHT   = 3'd7;

    localparam logic [9:0] LEAKY_SLOPE = 10'd819;

    function automatic logic [11:0] sig_tab(input logic [4:0] i);
        logic [11:0] v;
        case (i)
            5'd0:    v = 12'd1;
            5'd1:    v = 12'd4;
            5'd2:    v = 12'd10;
            5'd3:    v = 12'd27;
            5'd4:    v = 12'd74;
            5'd5:    v = 12'd194;
            5'd6:    v = 12'd488;
            5'd7:    v = 12'd1102;
            5'd8:    v = 12'd2048;
            5'd9:    v = 12'd2994;
            5'd10:   v = 12'd3608;
            5'd11:   v = 12'd3902;
            5'd12:   v = 12'd4022;
            5'd13:   v = 12'd4069;
            5'd14:   v = 12'd4086;
            5'd15:   v = 12'd4092;
            default: v = 12'd4095;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/conv2d_layer_dilated.sv -----
// Top level of the dilated 2-D convolution layer with activation.
// Depends on cdl_pkg for states, codes and the sigmoid table.
//
// Load beats (weight, bias, sample) are taken one per cycle while the block is
// idle. A compute beat names an output position; the block then produces one
// result beat per output channel. Each result takes input_channels *
// kernel_edge^2 taps of multiply-accumulate, one tap per cycle from the image
// and weight memories, then pipeline drain, rounding and activation, and then
// waits until it is taken. A position outside the output area gives a single
// result beat with status set in the cycle after acceptance. The input is ready
// only while no compute beat is in work. Memories need no clearing pass.
`default_nettype none
module conv2d_layer_dilated
    import cdl_pkg::*;
#(
    parameter int MAX_WIDTH        = 64,
    parameter int MAX_HEIGHT       = 64,
    parameter int MAX_IN_CHANNELS  = 8,
    parameter int MAX_OUT_CHANNELS = 32,
    parameter int MAX_KERNEL       = 7
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [6:0]  cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // row[5:0] column[11:6] channel[14:12] filter[19:15] tap_row[22:20]
    // tap_column[25:23] value[41:26]
    input  wire logic [47:0] s_tdata,
    // mode[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // result_value[15:0] filter_index[20:16]
    output logic [23:0]      m_tdata,
    output logic             m_tlast,
    // status[0]
    output logic             m_tuser
);

    localparam int IMG_D  = MAX_WIDTH * MAX_HEIGHT * MAX_IN_CHANNELS;
    localparam int WGT_D  = MAX_OUT_CHANNELS * MAX_KERNEL * MAX_KERNEL * MAX_IN_CHANNELS;
    localparam int IMG_AW = (IMG_D > 1) ? $clog2(IMG_D) : 1;
    localparam int WGT_AW = (WGT_D > 1) ? $clog2(WGT_D) : 1;
    localparam int NW     = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
    localparam int CW     = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;
    localparam int KW     = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int OUT_LIM = (MAX_OUT_CHANNELS < 32) ? MAX_OUT_CHANNELS : 32;

    cdl_state_t state_reg, state_next;

    logic [2:0] kernel_reg, dilation_reg, act_reg;
    logic [1:0] padding_reg;
    logic [3:0] in_ch_reg;
    logic [5:0] out_ch_reg;
    logic [6:0] width_reg, height_reg;

    logic signed [15:0] bias_reg [MAX_OUT_CHANNELS];
    logic signed [15:0] img_mem [IMG_D];
    logic signed [15:0] wgt_mem [WGT_D];
    logic signed [15:0] img_rd_reg, wgt_rd_reg;

    logic [5:0]  row_reg, col_reg;
    logic [NW-1:0] n_reg;
    logic [CW-1:0] c_reg;
    logic [KW-1:0] ky_reg, kx_reg;
    logic        tap_ok_reg, rdv_reg, prodv_reg;
    logic signed [31:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [15:0] rnd_reg, res_reg;
    logic signed [27:0] mul_reg;
    logic [11:0] base_reg;
    logic        oob_reg;

    // Field unpacking.
    logic [5:0]  in_row, in_col;
    logic [2:0]  in_ch, in_ty, in_tx;
    logic [4:0]  in_flt;
    logic signed [15:0] in_val;
    logic        s_acc, m_acc;

    assign in_row = s_tdata[5:0];
    assign in_col = s_tdata[11:6];
    assign in_ch  = s_tdata[14:12];
    assign in_flt = s_tdata[19:15];
    assign in_ty  = s_tdata[22:20];
    assign in_tx  = s_tdata[25:23];
    assign in_val = s_tdata[41:26];
    assign s_acc  = s_tvalid && s_tready;
    assign m_acc  = m_tvalid && m_tready;

    // Effective configuration.
    logic [3:0] k_eff, radius;
    logic [2:0] d_eff;
    logic [6:0] cin_eff, cout_eff;
    logic [10:0] w_eff, h_eff;
    logic [6:0] pad;

    always_comb
    begin
        if (kernel_reg == 3'd0)
            k_eff = 4'd1;
        else if (int'(kernel_reg) > MAX_KERNEL)
            k_eff = 4'(MAX_KERNEL);
        else
            k_eff = 4'(kernel_reg);
        if (dilation_reg == 3'd0)
            d_eff = 3'd1;
        else if (dilation_reg > 3'd4)
            d_eff = 3'd4;
        else
            d_eff = dilation_reg;
        if (in_ch_reg == 4'd0)
            cin_eff = 7'd1;
        else if (int'(in_ch_reg) > MAX_IN_CHANNELS)
            cin_eff = 7'(MAX_IN_CHANNELS);
        else
            cin_eff = 7'(in_ch_reg);
        if (out_ch_reg == 6'd0)
            cout_eff = 7'd1;
        else if (int'(out_ch_reg) > OUT_LIM)
            cout_eff = 7'(OUT_LIM);
        else
            cout_eff = 7'(out_ch_reg);
        if (width_reg == 7'd0)
            w_eff = 11'd1;
        else if (int'(width_reg) > MAX_WIDTH)
            w_eff = 11'(MAX_WIDTH);
        else
            w_eff = 11'(width_reg);
        if (height_reg == 7'd0)
            h_eff = 11'd1;
        else if (int'(height_reg) > MAX_HEIGHT)
            h_eff = 11'(MAX_HEIGHT);
        else
            h_eff = 11'(height_reg);
    end

    assign radius = k_eff >> 1;
    assign pad = (padding_reg == PAD_VALID) ? 7'((k_eff - 4'd1) >> 1) * 7'(d_eff) : 7'd0;

    // Output area check for an incoming compute beat.
    logic signed [12:0] oh, ow;
    logic in_oob;
    assign oh = $signed(13'(h_eff)) - $signed(13'({pad, 1'b0}));
    assign ow = $signed(13'(w_eff)) - $signed(13'({pad, 1'b0}));
    assign in_oob = ($signed(13'(in_row)) >= oh) || ($signed(13'(in_col)) >= ow);

    // Tap coordinates.
    logic signed [5:0]  dy, dx;
    logic signed [9:0]  offy, offx;
    logic signed [12:0] yp, xp, yc, xc;
    logic tap_in, tap_ok, tap_last;
    logic [IMG_AW-1:0] img_ra;
    logic [WGT_AW-1:0] wgt_ra;

    always_comb
    begin
        dy = $signed(6'(ky_reg)) - $signed(6'(radius));
        dx = $signed(6'(kx_reg)) - $signed(6'(radius));
        offy = 10'(dy) * $signed({7'd0, d_eff});
        offx = 10'(dx) * $signed({7'd0, d_eff});
        yp = $signed(13'(row_reg)) + $signed(13'(pad)) + 13'(offy);
        xp = $signed(13'(col_reg)) + $signed(13'(pad)) + 13'(offx);
        tap_in = (yp >= 0) && (yp < $signed(13'(h_eff))) && (xp >= 0)
            && (xp < $signed(13'(w_eff)));
        tap_ok = tap_in || (padding_reg == PAD_CLAMP);
        if (yp < 0)
            yc = 13'sd0;
        else if (yp >= $signed(13'(h_eff)))
            yc = $signed(13'(h_eff)) - 13'sd1;
        else
            yc = yp;
        if (xp < 0)
            xc = 13'sd0;
        else if (xp >= $signed(13'(w_eff)))
            xc = $signed(13'(w_eff)) - 13'sd1;
        else
            xc = xp;
        img_ra = IMG_AW'((int'(yc) * MAX_WIDTH + int'(xc)) * MAX_IN_CHANNELS + int'(c_reg));
        wgt_ra = WGT_AW'(((int'(n_reg) * MAX_KERNEL + int'(ky_reg)) * MAX_KERNEL
            + int'(kx_reg)) * MAX_IN_CHANNELS + int'(c_reg));
        tap_last = (4'(kx_reg) == k_eff - 4'd1) && (4'(ky_reg) == k_eff - 4'd1)
            && (7'(c_reg) == cin_eff - 7'd1);
    end

    // Load addressing.
    logic img_we, wgt_we, bias_we;
    logic [IMG_AW-1:0] img_wa;
    logic [WGT_AW-1:0] wgt_wa;

    assign img_we = s_acc && (s_tuser == MODE_SAMPLE) && (int'(in_row) < MAX_HEIGHT)
        && (int'(in_col) < MAX_WIDTH) && (int'(in_ch) < MAX_IN_CHANNELS);
    assign wgt_we = s_acc && (s_tuser == MODE_WEIGHT) && (int'(in_flt) < MAX_OUT_CHANNELS)
        && (int'(in_ty) < MAX_KERNEL) && (int'(in_tx) < MAX_KERNEL)
        && (int'(in_ch) < MAX_IN_CHANNELS);
    assign bias_we = s_acc && (s_tuser == MODE_BIAS) && (int'(in_flt) < MAX_OUT_CHANNELS);
    assign img_wa = IMG_AW'((int'(in_row) * MAX_WIDTH + int'(in_col)) * MAX_IN_CHANNELS
        + int'(in_ch));
    assign wgt_wa = WGT_AW'(((int'(in_flt) * MAX_KERNEL + int'(in_ty)) * MAX_KERNEL
        + int'(in_tx)) * MAX_IN_CHANNELS + int'(in_ch));

    always_ff @(posedge clk)
    begin
        if (img_we)
            img_mem[img_wa] <= in_val;
        img_rd_reg <= img_mem[img_ra];
    end

    always_ff @(posedge clk)
    begin
        if (wgt_we)
            wgt_mem[wgt_wa] <= in_val;
        wgt_rd_reg <= wgt_mem[wgt_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_OUT_CHANNELS; i++)
                bias_reg[i] <= 16'sd0;
        end
        else if (bias_we)
        begin
            bias_reg[NW'(in_flt)] <= in_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg   <= 3'd3;
            dilation_reg <= 3'd1;
            padding_reg  <= 2'd0;
            act_reg      <= 3'd0;
            in_ch_reg    <= 4'd1;
            out_ch_reg   <= 6'd1;
            width_reg    <= 7'd64;
            height_reg   <= 7'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KERNEL:   kernel_reg   <= cfg_data[2:0];
                REG_DILATION: dilation_reg <= cfg_data[2:0];
                REG_PADDING:  padding_reg  <= cfg_data[1:0];
                REG_ACT:      act_reg      <= cfg_data[2:0];
                REG_IN_CH:    in_ch_reg    <= cfg_data[3:0];
                REG_OUT_CH:   out_ch_reg   <= cfg_data[5:0];
                REG_WIDTH:    width_reg    <= cfg_data;
                REG_HEIGHT:   height_reg   <= cfg_data;
                default:      act_reg      <= act_reg;
            endcase
        end
    end

    logic last_filter;
    assign last_filter = (7'(n_reg) == cout_eff - 7'd1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_acc && (s_tuser == MODE_COMPUTE))
                    state_next = in_oob ? ST_OUT : ST_MAC;
            ST_MAC:
                if (tap_last)
                    state_next = ST_DRAIN;
            ST_DRAIN:
                if (!rdv_reg && !prodv_reg)
                    state_next = ST_RND;
            ST_RND:
                state_next = ST_ACT;
            ST_ACT:
                state_next = ST_FIN;
            ST_FIN:
                state_next = ST_OUT;
            ST_OUT:
                if (m_tready)
                    state_next = (oob_reg || last_filter) ? ST_IDLE : ST_MAC;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_OUT);
        m_tdata  = {3'd0, oob_reg ? 5'd0 : 5'(n_reg), oob_reg ? 16'd0 : res_reg};
        m_tlast  = oob_reg || last_filter;
        m_tuser  = oob_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rdv_reg   <= 1'b0;
            prodv_reg <= 1'b0;
            oob_reg   <= 1'b0;
            n_reg     <= '0;
            c_reg     <= '0;
            ky_reg    <= '0;
            kx_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rdv_reg   <= (state_reg == ST_MAC);
            prodv_reg <= rdv_reg;
            if (state_reg == ST_IDLE && s_acc && s_tuser == MODE_COMPUTE)
            begin
                oob_reg <= in_oob;
                n_reg   <= '0;
            end
            else if (state_reg == ST_OUT && m_acc && !oob_reg && !last_filter)
            begin
                n_reg <= n_reg + 1'b1;
            end
            if (state_reg == ST_MAC)
            begin
                if (4'(kx_reg) == k_eff - 4'd1)
                begin
                    kx_reg <= '0;
                    if (4'(ky_reg) == k_eff - 4'd1)
                    begin
                        ky_reg <= '0;
                        c_reg  <= tap_last ? '0 : c_reg + 1'b1;
                    end
                    else
                    begin
                        ky_reg <= ky_reg + 1'b1;
                    end
                end
                else
                begin
                    kx_reg <= kx_reg + 1'b1;
                end
            end
        end
    end

    // Datapath: product, accumulate, round, activation.
    logic signed [ACC_W-1:0] acc_t, acc_init;
    logic signed [ACC_W-13:0] acc_q;
    logic signed [16:0] dbl;
    logic signed [15:0] sx, sig_v, leaky_v;
    logic [4:0] idx;
    logic [11:0] dlt;
    logic signed [27:0] lk_t;
    logic signed [15:0] lk_q;

    always_comb
    begin
        acc_init = {{(ACC_W - 28){bias_reg[n_reg][15]}}, bias_reg[n_reg], 12'd0};
        acc_t = acc_reg + ACC_W'(2048);
        acc_q = acc_t[ACC_W-1:12];
        dbl = {rnd_reg, 1'b0};
        if (act_reg == ACT_TANH)
            sx = (dbl > 17'sd32767) ? 16'sd32767 : ((dbl < -17'sd32768) ? -16'sd32768
                : dbl[15:0]);
        else
            sx = rnd_reg;
        idx = {1'b0, ~sx[15], sx[14:12]};
        dlt = sig_tab(idx + 5'd1) - sig_tab(idx);
        sig_v = $signed(16'(base_reg) + 16'((mul_reg[21:0] + 22'd2048) >> 12));
        lk_t = mul_reg + 28'sd2048;
        lk_q = lk_t[27:12];
        leaky_v = lk_q;
    end

    always_ff @(posedge clk)
    begin
        tap_ok_reg <= tap_ok;
        prod_reg   <= tap_ok_reg ? img_rd_reg * wgt_rd_reg : 32'sd0;
        if ((state_reg == ST_MAC) && !rdv_reg)
            acc_reg <= acc_init;
        else if (prodv_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        if ((state_reg == ST_IDLE) && s_acc)
        begin
            row_reg <= in_row;
            col_reg <= in_col;
        end
        if (state_reg == ST_RND)
        begin
            if (acc_q > $signed((ACC_W-12)'(32767)))
                rnd_reg <= 16'sd32767;
            else if (acc_q < -$signed((ACC_W-12)'(32768)))
                rnd_reg <= -16'sd32768;
            else
                rnd_reg <= acc_q[15:0];
        end
        if (state_reg == ST_ACT)
        begin
            base_reg <= sig_tab(idx);
            if (act_reg == ACT_LEAKY)
                mul_reg <= 28'(rnd_reg) * $signed({1'b0, LEAKY_SLOPE});
            else
                mul_reg <= $signed({16'd0, dlt}) * $signed({16'd0, sx[11:0]});
        end
        if (state_reg == ST_FIN)
        begin
            case (act_reg)
                ACT_RELU:    res_reg <= rnd_reg[15] ? 16'sd0 : rnd_reg;
                ACT_TANH:    res_reg <= {sig_v[14:0], 1'b0} - 16'sd4096;
                ACT_SIGMOID: res_reg <= sig_v;
                ACT_LEAKY:   res_reg <= rnd_reg[15] ? leaky_v : rnd_reg;
                default:     res_reg <= rnd_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/cdl_checker.sv -----
// Port-level checker for the dilated convolution layer.
// Depends on nothing but the top level's ports; bound to conv2d_layer_dilated.
`default_nettype none
module cdl_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic        m_tuser
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("Result beat dropped while stalled.");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("Result beat changed while stalled.");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == 24'd0))
        else $error("Status beat is not a lone zero beat.");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("Input ready while a result is pending.");

endmodule

bind conv2d_layer_dilated cdl_checker u_cdl_checker (.*);
`default_nettype wire

// ----- sim/tb_conv2d_layer_dilated.sv -----
// Self-checking testbench for the dilated 2-D convolution layer.
// Loads stores, sweeps register settings and checks every result beat against
// an in-bench fixed-point predictor. Depends on cdl_pkg and conv2d_layer_dilated.
`timescale 1ns / 1ps

module tb_conv2d_layer_dilated
    import cdl_pkg::*;
();

    typedef struct packed {
        logic [1:0]         mode;
        logic [5:0]         row;
        logic [5:0]         col;
        logic [2:0]         ch;
        logic [4:0]         flt;
        logic [2:0]         ty;
        logic [2:0]         tx;
        logic signed [15:0] val;
    } layer_item_t;

    typedef struct packed {
        logic [15:0] value;
        logic [4:0]  filter;
        logic        last;
        logic        status;
    } layer_result_t;

    localparam int IMG_N = 64 * 64 * 8;
    localparam int WGT_N = 32 * 7 * 7 * 8;
    localparam int SIG_TAB [0:16] = '{1, 4, 10, 27, 74, 194, 488, 1102, 2048,
                                      2994, 3608, 3902, 4022, 4069, 4086, 4092, 4095};

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [6:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    conv2d_layer_dilated u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    layer_item_t   pending_beats[$];
    layer_result_t expected_results[$];
    layer_item_t   cur_beat;
    bit            beat_taken;
    int            send_idle;
    int            recv_idle;
    int            err_count;

    logic signed [15:0] img_mem [0:IMG_N-1];
    logic signed [15:0] wgt_mem [0:WGT_N-1];
    logic signed [15:0] bias_mem [0:31];
    bit                 img_ok [0:IMG_N-1];
    bit                 wgt_ok [0:WGT_N-1];

    logic [6:0] reg_shadow [0:7];
    int k_eff, d_eff, pm_eff, act_eff, cin_eff, cout_eff, w_eff, h_eff, pad_eff, oh_eff, ow_eff;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int clamp_int(input int v, input int lo, input int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int img_addr(input int r, input int c, input int ch);
        return (r * 64 + c) * 8 + ch;
    endfunction

    function automatic int wgt_addr(input int f, input int ky, input int kx, input int ch);
        return ((f * 7 + ky) * 7 + kx) * 8 + ch;
    endfunction

    function automatic int sat16(input longint v);
        return v < -32768 ? -32768 : (v > 32767 ? 32767 : int'(v));
    endfunction

    function automatic int round_q12(input longint acc);
        return sat16((acc + 2048) >>> 12);
    endfunction

    function automatic int sigmoid_lin(input int x);
        int off;
        int seg;
        int frac;
        int slope;
        off   = x + 32768;
        seg   = (off >> 12) & 15;
        frac  = off & 4095;
        slope = SIG_TAB[seg + 1] - SIG_TAB[seg];
        return SIG_TAB[seg] + ((slope * frac + 2048) >> 12);
    endfunction

    function automatic int activate(input int x);
        case (act_eff)
            int'(ACT_RELU):    return x < 0 ? 0 : x;
            int'(ACT_TANH):    return 2 * sigmoid_lin(sat16(longint'(x) * 2)) - 4096;
            int'(ACT_SIGMOID): return sigmoid_lin(x);
            int'(ACT_LEAKY):   return x < 0 ? round_q12(longint'(x) * int'(LEAKY_SLOPE)) : x;
            default:           return x;
        endcase
    endfunction

    function automatic void derive_geometry();
        k_eff    = clamp_int(reg_shadow[REG_KERNEL], 1, 7);
        d_eff    = clamp_int(reg_shadow[REG_DILATION], 1, 4);
        pm_eff   = reg_shadow[REG_PADDING];
        act_eff  = reg_shadow[REG_ACT];
        cin_eff  = clamp_int(reg_shadow[REG_IN_CH], 1, 8);
        cout_eff = clamp_int(reg_shadow[REG_OUT_CH], 1, 32);
        w_eff    = clamp_int(reg_shadow[REG_WIDTH], 1, 64);
        h_eff    = clamp_int(reg_shadow[REG_HEIGHT], 1, 64);
        pad_eff  = (pm_eff == int'(PAD_VALID)) ? ((k_eff - 1) / 2) * d_eff : 0;
        oh_eff   = h_eff - 2 * pad_eff;
        ow_eff   = w_eff - 2 * pad_eff;
    endfunction

    // Maps a tap to its image position; returns 0 when the tap reads the zero border.
    function automatic bit tap_position(input int row, input int col, input int ky,
                                        input int kx, output int yp, output int xp);
        yp = row + pad_eff + (ky - k_eff / 2) * d_eff;
        xp = col + pad_eff + (kx - k_eff / 2) * d_eff;
        if (pm_eff == int'(PAD_CLAMP))
        begin
            yp = clamp_int(yp, 0, h_eff - 1);
            xp = clamp_int(xp, 0, w_eff - 1);
            return 1'b1;
        end
        return !(yp < 0 || yp >= h_eff || xp < 0 || xp >= w_eff);
    endfunction

    function automatic void predict_layer(input layer_item_t it);
        layer_result_t res;
        longint        acc;
        int            yp;
        int            xp;
        case (it.mode)
            MODE_WEIGHT:
                if (it.ty < 7 && it.tx < 7)
                    wgt_mem[wgt_addr(it.flt, it.ty, it.tx, it.ch)] = it.val;
            MODE_BIAS:
                bias_mem[it.flt] = it.val;
            MODE_SAMPLE:
                img_mem[img_addr(it.row, it.col, it.ch)] = it.val;
            default:
                if (int'(it.row) >= oh_eff || int'(it.col) >= ow_eff)
                begin
                    res = '{value: 16'd0, filter: 5'd0, last: 1'b1, status: 1'b1};
                    expected_results.push_back(res);
                end
                else
                begin
                    for (int n = 0; n < cout_eff; n++)
                    begin
                        acc = longint'(bias_mem[n]) * 4096;
                        for (int c = 0; c < cin_eff; c++)
                            for (int ky = 0; ky < k_eff; ky++)
                                for (int kx = 0; kx < k_eff; kx++)
                                    if (tap_position(it.row, it.col, ky, kx, yp, xp))
                                        acc += longint'(img_mem[img_addr(yp, xp, c)]) *
                                               longint'(wgt_mem[wgt_addr(n, ky, kx, c)]);
                        res.value  = 16'(activate(round_q12(acc)));
                        res.filter = 5'(n);
                        res.last   = (n == cout_eff - 1);
                        res.status = 1'b0;
                        expected_results.push_back(res);
                    end
                end
        endcase
    endfunction

    function automatic logic signed [15:0] rand_value();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 8192)) - 16'sd4096;
    endfunction

    task automatic queue_beat(input logic [1:0] mode, input int row, input int col,
                              input int ch, input int flt, input int ty, input int tx,
                              input logic signed [15:0] val);
        layer_item_t it;
        it = '{mode: mode, row: 6'(row), col: 6'(col), ch: 3'(ch), flt: 5'(flt),
               ty: 3'(ty), tx: 3'(tx), val: val};
        if (mode == MODE_SAMPLE)
            img_ok[img_addr(it.row, it.col, it.ch)] = 1'b1;
        if (mode == MODE_WEIGHT && it.ty < 7 && it.tx < 7)
            wgt_ok[wgt_addr(it.flt, it.ty, it.tx, it.ch)] = 1'b1;
        pending_beats.push_back(it);
    endtask

    // Queues unloaded samples and weights this compute reads, then the compute beat.
    task automatic compute_at(input int row, input int col);
        int yp;
        int xp;
        if (row < oh_eff && col < ow_eff)
        begin
            for (int c = 0; c < cin_eff; c++)
                for (int ky = 0; ky < k_eff; ky++)
                    for (int kx = 0; kx < k_eff; kx++)
                    begin
                        if (tap_position(row, col, ky, kx, yp, xp) && !img_ok[img_addr(yp, xp, c)])
                            queue_beat(MODE_SAMPLE, yp, xp, c, 0, 0, 0, rand_value());
                        for (int n = 0; n < cout_eff; n++)
                            if (!wgt_ok[wgt_addr(n, ky, kx, c)])
                                queue_beat(MODE_WEIGHT, 0, 0, c, n, ky, kx, rand_value());
                    end
        end
        queue_beat(MODE_COMPUTE, row, col, $urandom_range(0, 7), $urandom_range(0, 31),
                   $urandom_range(0, 7), $urandom_range(0, 7), 16'($urandom));
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 7'(val);
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_KERNEL, REG_DILATION, REG_ACT: reg_shadow[idx] = 7'(val & 7);
            REG_PADDING:                       reg_shadow[idx] = 7'(val & 3);
            REG_IN_CH:                         reg_shadow[idx] = 7'(val & 15);
            REG_OUT_CH:                        reg_shadow[idx] = 7'(val & 63);
            default:                           reg_shadow[idx] = 7'(val);
        endcase
        derive_geometry();
    endtask

    task automatic set_layer(input int k, input int d, input int pm, input int act,
                             input int cin, input int cout, input int w, input int h);
        write_reg(REG_KERNEL, k);
        write_reg(REG_DILATION, d);
        write_reg(REG_PADDING, pm);
        write_reg(REG_ACT, act);
        write_reg(REG_IN_CH, cin);
        write_reg(REG_OUT_CH, cout);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    task automatic random_traffic(input int count);
        int pick;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                if (oh_eff > 0 && ow_eff > 0 && $urandom_range(0, 9) < 7)
                    compute_at($urandom_range(0, oh_eff - 1), $urandom_range(0, ow_eff - 1));
                else
                    compute_at($urandom_range(0, 63), $urandom_range(0, 63));
            end
            else if (pick < 55)
                queue_beat(MODE_SAMPLE, $urandom_range(0, h_eff - 1), $urandom_range(0, w_eff - 1),
                           $urandom_range(0, cin_eff - 1), $urandom_range(0, 31),
                           $urandom_range(0, 7), $urandom_range(0, 7), rand_value());
            else if (pick < 75)
                queue_beat(MODE_WEIGHT, $urandom_range(0, 63), $urandom_range(0, 63),
                           $urandom_range(0, cin_eff - 1), $urandom_range(0, cout_eff - 1),
                           $urandom_range(0, k_eff - 1), $urandom_range(0, k_eff - 1),
                           rand_value());
            else if (pick < 85)
                queue_beat(MODE_BIAS, $urandom_range(0, 63), $urandom_range(0, 63),
                           $urandom_range(0, 7), $urandom_range(0, 31),
                           $urandom_range(0, 7), $urandom_range(0, 7), rand_value());
            else if (pick < 92)
                queue_beat(MODE_WEIGHT, 0, 0, $urandom_range(0, 7), $urandom_range(0, 31),
                           7, $urandom_range(0, 7), rand_value());
            else
                queue_beat(MODE_SAMPLE, $urandom_range(0, 63), $urandom_range(0, 63),
                           $urandom_range(0, 7), 0, 0, 0, rand_value());
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            predict_layer(cur_beat);
            beat_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || beat_taken))
        begin
            beat_taken = 1'b0;
            if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle)
            begin
                cur_beat = pending_beats.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {6'd0, cur_beat.val, cur_beat.tx, cur_beat.ty, cur_beat.flt,
                             cur_beat.ch, cur_beat.col, cur_beat.row};
                s_tuser  <= cur_beat.mode;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        layer_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("Unexpected result beat: value %h filter %0d last %b status %b",
                             m_tdata[15:0], m_tdata[20:16], m_tlast, m_tuser);
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[15:0] !== want.value || m_tdata[20:16] !== want.filter ||
                    m_tlast !== want.last || m_tuser !== want.status)
                begin
                    err_count++;
                    if (err_count <= 10)
                    begin
                        $display("Mismatch: expected value %h filter %0d last %b status %b",
                                 want.value, want.filter, want.last, want.status);
                        $display("          got value %h filter %0d last %b status %b",
                                 m_tdata[15:0], m_tdata[20:16], m_tlast, m_tuser);
                    end
                end
            end
        end
    end

    initial
    begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        beat_taken = 1'b0;
        err_count  = 0;
        send_idle  = 6;
        recv_idle  = 85;
        for (int i = 0; i < 32; i++)
            bias_mem[i] = '0;
        reg_shadow = '{7'd3, 7'd1, 7'd0, 7'd0, 7'd1, 7'd1, 7'd64, 7'd64};
        derive_geometry();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        compute_at(0, 0);
        queue_beat(MODE_BIAS, 0, 0, 0, 0, 0, 0, 16'sh7fff);
        queue_beat(MODE_SAMPLE, 1, 1, 0, 0, 0, 0, 16'sh7fff);
        queue_beat(MODE_WEIGHT, 0, 0, 0, 0, 1, 1, 16'sh7fff);
        compute_at(0, 0);
        queue_beat(MODE_SAMPLE, 1, 1, 0, 0, 0, 0, 16'sh8000);
        compute_at(0, 0);
        queue_beat(MODE_BIAS, 0, 0, 0, 0, 0, 0, 16'sh8000);
        compute_at(0, 0);
        queue_beat(MODE_WEIGHT, 0, 0, 7, 31, 7, 0, -16'sd1);
        queue_beat(MODE_WEIGHT, 0, 0, 0, 0, 0, 7, -16'sd1);
        queue_beat(MODE_WEIGHT, 0, 0, 0, 0, 7, 7, 16'sh7fff);
        compute_at(0, 0);
        compute_at(62, 0);
        compute_at(0, 62);
        compute_at(63, 63);
        compute_at(61, 61);
        random_traffic(6);
        wait_drained();

        for (int phase = 1; phase <= 8; phase++)
        begin
            send_idle = (phase <= 2) ? 6 : (phase <= 5) ? 85 : 0;
            recv_idle = (phase <= 2) ? 85 : (phase <= 5) ? 6 : 0;
            case (phase)
                1: set_layer(1, 1, PAD_CLAMP, ACT_RELU, 4, 4, 8, 8);
                2: set_layer(5, 4, 1, ACT_TANH, 1, 1, 5, 5);
                3: set_layer(3, 2, PAD_CLAMP, ACT_SIGMOID, 1, 2, 4, 4);
                4: set_layer(3, 3, PAD_VALID, ACT_LEAKY, 1, 2, 9, 9);
                5: set_layer(7, 1, PAD_VALID, 0, 1, 1, 1, 1);
                6: set_layer(0, 0, 3, 7, 15, 0, 0, 127);
                7: set_layer(1, 7, 1, 5, 1, 63, 100, 3);
                default: set_layer(2, 1, PAD_CLAMP, ACT_TANH, 1, 2, 6, 6);
            endcase
            random_traffic(6);
            wait_drained();
        end

        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/cdl_pkg.sv
rtl/conv2d_layer_dilated.sv
rtl/cdl_checker.sv
sim/tb_conv2d_layer_dilated.sv
